[rtl/fdr_pkg.sv]
// Package for the dielectric Fresnel reflectance pipeline.
// Fixed-point constants, stage counts and the carry record shared by the stages.
// No dependencies.
package fdr_pkg;

   localparam int unsigned ONE_Q15     = 32768;
   localparam int unsigned ONE_Q30     = 1073741824;
   localparam int          DIV1_STEPS  = 30;   // quotient bits of sin2t * 2^24 / n^2
   localparam int          SQRT_STEPS  = 16;   // root bits of 2^30 - sin2i
   localparam int          DIV2_STEPS  = 31;   // quotient bits of |a - b| * 2^30 / (a + b)
   localparam int          ROUND_SHIFT = 46;   // Q.60 sum of squares down to Q.15 mean

   // fields that ride along with an item through the pipeline
   typedef struct packed {
      logic        tir;
      logic [15:0] n;
      logic [15:0] c;
      logic [30:0] nc;
      logic [15:0] ci;
   } carry_type;

   typedef struct packed {
      logic [15:0] refl;
      logic [15:0] ci;
      logic        tir;
   } result_type;

endpackage

[rtl/dielectric_fresnel_reflectance.sv]
// Dielectric Fresnel reflectance, fully pipelined with one item per cycle.
// Depends on fdr_pkg (constants, carry and result records).
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata: eta_ratio Q4.12, cos_view Q1.15
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: reflectance, cos_transmit; tuser: tir
//
// One transaction enters per cycle while the skid register is empty.
// Depth is set by the bit-serial stages: 30 for Snell's division, 16 for the root,
// 31 for the two amplitude-ratio divisions, plus product, square and round stages.
// Reset (synchronous) clears all valid bits; data registers are not reset.
// A skid register behind the output lets one more result land while rsp stalls;
// the whole pipeline holds while the skid register is full.
module dielectric_fresnel_reflectance
   import fdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] eta_ratio, [31:16] cos_view
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] reflectance, [31:16] cos_transmit
   output logic        rsp_tuser    // [0] total_reflect
);

   logic skid_v_ff;
   logic en;
   assign en = !skid_v_ff;
   assign req_tready = en;

   // ---------------- stage 1: clamp, products ----------------
   logic        s1_v_ff;
   logic [15:0] s1_n_ff, s1_c_ff;
   logic [30:0] s1_cc_ff, s1_nc_ff;
   logic [31:0] s1_nn_ff;
   logic [15:0] c_clamp;

   assign c_clamp = (req_tdata[31:16] > 16'(ONE_Q15)) ? 16'(ONE_Q15) : req_tdata[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
      if (en) begin
         s1_n_ff  <= req_tdata[15:0];
         s1_c_ff  <= c_clamp;
         s1_cc_ff <= {15'd0, c_clamp} * {15'd0, c_clamp};
         s1_nn_ff <= req_tdata[15:0] * req_tdata[15:0];
         s1_nc_ff <= {15'd0, req_tdata[15:0]} * {15'd0, c_clamp};
      end
   end

   // ---------------- Snell division, one quotient bit per stage ----------------
   logic              d1_v_ff   [0:DIV1_STEPS];
   logic [31:0]       d1_rem_ff [0:DIV1_STEPS];
   logic [DIV1_STEPS-1:0] d1_quo_ff [0:DIV1_STEPS];
   logic [5:0]        d1_low_ff [0:DIV1_STEPS];
   logic [31:0]       d1_nn_ff  [0:DIV1_STEPS];
   carry_type         d1_cy_ff  [0:DIV1_STEPS];

   logic [30:0] sin2t;
   logic        tir_in;
   carry_type   cy_in;

   assign sin2t  = 31'(ONE_Q30) - s1_cc_ff;
   // sin2i >= 1 exactly when sin2t >= n^2 * 2^6; n = 0 lands here too
   assign tir_in = {7'd0, sin2t} >= {s1_nn_ff, 6'd0};

   always_comb begin
      cy_in     = '0;
      cy_in.tir = tir_in;
      cy_in.n   = s1_n_ff;
      cy_in.c   = s1_c_ff;
      cy_in.nc  = s1_nc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff[0] <= 1'b0;
      end else if (en) begin
         d1_v_ff[0] <= s1_v_ff;
      end
      if (en) begin
         d1_rem_ff[0] <= {7'd0, sin2t[30:6]};
         d1_quo_ff[0] <= '0;
         d1_low_ff[0] <= sin2t[5:0];
         d1_nn_ff[0]  <= s1_nn_ff;
         d1_cy_ff[0]  <= cy_in;
      end
   end

   for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
      logic        bit_in;
      logic [32:0] trial;
      logic        ge;
      if (k < 6) begin : g_low
         assign bit_in = d1_low_ff[k][5-k];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end
      assign trial = {d1_rem_ff[k], bit_in};
      assign ge    = trial >= {1'b0, d1_nn_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            d1_v_ff[k+1] <= d1_v_ff[k];
         end
         if (en) begin
            d1_rem_ff[k+1] <= ge ? 32'(trial - {1'b0, d1_nn_ff[k]}) : trial[31:0];
            d1_quo_ff[k+1] <= {d1_quo_ff[k][DIV1_STEPS-2:0], ge};
            d1_low_ff[k+1] <= d1_low_ff[k];
            d1_nn_ff[k+1]  <= d1_nn_ff[k];
            d1_cy_ff[k+1]  <= d1_cy_ff[k];
         end
      end
   end

   // ---------------- square root of 1 - sin2i, one root bit per stage ----------------
   logic        sq_v   [0:SQRT_STEPS];
   logic [30:0] sq_val [0:SQRT_STEPS];
   logic [30:0] sq_root[0:SQRT_STEPS];
   carry_type   sq_cy  [0:SQRT_STEPS];

   assign sq_v[0]    = d1_v_ff[DIV1_STEPS];
   assign sq_val[0]  = 31'(ONE_Q30) - {1'b0, d1_quo_ff[DIV1_STEPS]};
   assign sq_root[0] = '0;
   assign sq_cy[0]   = d1_cy_ff[DIV1_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [30:0] BITC = 31'(1) << (2 * (SQRT_STEPS - 1 - j));
      logic [30:0] t;
      logic        ge;
      logic        v_ff;
      logic [30:0] val_ff, root_ff;
      carry_type   cy_ff;
      assign t  = sq_root[j] + BITC;
      assign ge = sq_val[j] >= t;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= sq_v[j];
         end
         if (en) begin
            val_ff  <= ge ? sq_val[j] - t : sq_val[j];
            root_ff <= ge ? (sq_root[j] >> 1) + BITC : sq_root[j] >> 1;
            cy_ff   <= sq_cy[j];
         end
      end
      assign sq_v[j+1]    = v_ff;
      assign sq_val[j+1]  = val_ff;
      assign sq_root[j+1] = root_ff;
      assign sq_cy[j+1]   = cy_ff;
   end

   // ---------------- ratio terms ----------------
   logic        p1_v_ff;
   carry_type   p1_cy_ff;
   logic [27:0] p1_a1_ff, p1_b2_ff;
   logic [30:0] p1_b1_ff;
   logic [31:0] p1_a2_ff;
   logic [15:0] ci_root;
   carry_type   cy_ci;

   // root of a value at most 2^30 never exceeds 32768
   assign ci_root = sq_root[SQRT_STEPS][15:0];

   always_comb begin
      cy_ci    = sq_cy[SQRT_STEPS];
      cy_ci.ci = ci_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= sq_v[SQRT_STEPS];
      end
      if (en) begin
         p1_cy_ff <= cy_ci;
         p1_a1_ff <= {ci_root[15:0], 12'd0};
         p1_b1_ff <= sq_cy[SQRT_STEPS].nc;
         p1_a2_ff <= sq_cy[SQRT_STEPS].n * ci_root;
         p1_b2_ff <= {sq_cy[SQRT_STEPS].c, 12'd0};
      end
   end

   logic [32:0] diff1, den1, diff2, den2;
   assign diff1 = ({5'd0, p1_a1_ff} >= {2'd0, p1_b1_ff}) ? {5'd0, p1_a1_ff} - {2'd0, p1_b1_ff}
                                                         : {2'd0, p1_b1_ff} - {5'd0, p1_a1_ff};
   assign den1  = {5'd0, p1_a1_ff} + {2'd0, p1_b1_ff};
   assign diff2 = ({1'b0, p1_a2_ff} >= {5'd0, p1_b2_ff}) ? {1'b0, p1_a2_ff} - {5'd0, p1_b2_ff}
                                                         : {5'd0, p1_b2_ff} - {1'b0, p1_a2_ff};
   assign den2  = {1'b0, p1_a2_ff} + {5'd0, p1_b2_ff};

   // ---------------- amplitude ratio divisions, two lanes ----------------
   logic                  d2_v_ff    [0:DIV2_STEPS];
   carry_type             d2_cy_ff   [0:DIV2_STEPS];
   logic [33:0]           d2_rem1_ff [0:DIV2_STEPS];
   logic [33:0]           d2_rem2_ff [0:DIV2_STEPS];
   logic [32:0]           d2_den1_ff [0:DIV2_STEPS];
   logic [32:0]           d2_den2_ff [0:DIV2_STEPS];
   logic [DIV2_STEPS-1:0] d2_quo1_ff [0:DIV2_STEPS];
   logic [DIV2_STEPS-1:0] d2_quo2_ff [0:DIV2_STEPS];
   logic                  d2_lsb1_ff [0:DIV2_STEPS];
   logic                  d2_lsb2_ff [0:DIV2_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff[0] <= 1'b0;
      end else if (en) begin
         d2_v_ff[0] <= p1_v_ff;
      end
      if (en) begin
         d2_cy_ff[0]   <= p1_cy_ff;
         d2_rem1_ff[0] <= {2'd0, diff1[32:1]};
         d2_rem2_ff[0] <= {2'd0, diff2[32:1]};
         d2_lsb1_ff[0] <= diff1[0];
         d2_lsb2_ff[0] <= diff2[0];
         d2_den1_ff[0] <= den1;
         d2_den2_ff[0] <= den2;
         d2_quo1_ff[0] <= '0;
         d2_quo2_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
      logic        b1, b2;
      logic [34:0] tr1, tr2;
      logic        ge1, ge2;
      if (k == 0) begin : g_first
         assign b1 = d2_lsb1_ff[k];
         assign b2 = d2_lsb2_ff[k];
      end else begin : g_rest
         assign b1 = 1'b0;
         assign b2 = 1'b0;
      end
      assign tr1 = {d2_rem1_ff[k], b1};
      assign tr2 = {d2_rem2_ff[k], b2};
      assign ge1 = tr1 >= {2'd0, d2_den1_ff[k]};
      assign ge2 = tr2 >= {2'd0, d2_den2_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            d2_v_ff[k+1] <= d2_v_ff[k];
         end
         if (en) begin
            d2_cy_ff[k+1]   <= d2_cy_ff[k];
            d2_rem1_ff[k+1] <= ge1 ? 34'(tr1 - {2'd0, d2_den1_ff[k]}) : tr1[33:0];
            d2_rem2_ff[k+1] <= ge2 ? 34'(tr2 - {2'd0, d2_den2_ff[k]}) : tr2[33:0];
            d2_quo1_ff[k+1] <= {d2_quo1_ff[k][DIV2_STEPS-2:0], ge1};
            d2_quo2_ff[k+1] <= {d2_quo2_ff[k][DIV2_STEPS-2:0], ge2};
            d2_lsb1_ff[k+1] <= d2_lsb1_ff[k];
            d2_lsb2_ff[k+1] <= d2_lsb2_ff[k];
            d2_den1_ff[k+1] <= d2_den1_ff[k];
            d2_den2_ff[k+1] <= d2_den2_ff[k];
         end
      end
   end

   // ---------------- squares, mean, rounding ----------------
   logic        sqr_v_ff;
   carry_type   sqr_cy_ff;
   logic [61:0] sqr1_ff, sqr2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqr_v_ff <= 1'b0;
      end else if (en) begin
         sqr_v_ff <= d2_v_ff[DIV2_STEPS];
      end
      if (en) begin
         sqr_cy_ff <= d2_cy_ff[DIV2_STEPS];
         sqr1_ff   <= d2_quo1_ff[DIV2_STEPS] * d2_quo1_ff[DIV2_STEPS];
         sqr2_ff   <= d2_quo2_ff[DIV2_STEPS] * d2_quo2_ff[DIV2_STEPS];
      end
   end

   logic [62:0] sum_sq;
   logic [16:0] mean_q15;
   result_type  fin_in;
   logic        fin_v_ff;
   result_type  fin_ff;

   assign sum_sq   = {1'b0, sqr1_ff} + {1'b0, sqr2_ff} + (63'(1) << (ROUND_SHIFT - 1));
   assign mean_q15 = 17'(sum_sq >> ROUND_SHIFT);

   always_comb begin
      if (sqr_cy_ff.tir) begin
         fin_in.refl = 16'(ONE_Q15);
         fin_in.ci   = '0;
         fin_in.tir  = 1'b1;
      end else begin
         fin_in.refl = (mean_q15 > 17'(ONE_Q15)) ? 16'(ONE_Q15) : mean_q15[15:0];
         fin_in.ci   = sqr_cy_ff.ci;
         fin_in.tir  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (en) begin
         fin_v_ff <= sqr_v_ff;
      end
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // ---------------- output register and skid ----------------
   logic       out_v_ff;
   result_type out_ff, skid_ff;
   logic       out_free;

   assign out_free = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= fin_v_ff;
         end
      end else if (fin_v_ff) begin
         skid_v_ff <= 1'b1;
      end
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : fin_ff;
      end else if (en) begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.ci, out_ff.refl};
   assign rsp_tuser  = out_ff.tir;

   // ---------------- assertions ----------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a result while the output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid filled without an output stall");

   a_tir_result: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.tir) |-> (out_ff.refl == 16'(ONE_Q15) && out_ff.ci == 16'd0))
      else $error("total reflection result malformed");

   a_normal_result: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ff.tir) |-> (out_ff.ci != 16'd0 && out_ff.refl <= 16'(ONE_Q15)))
      else $error("refracted result out of range");

endmodule
